// File: rtl/cpfm_pkg.sv
// Shared types, widths and reset values of the capture period frequency meter.
package cpfm_pkg;

  localparam int CAP_W    = 16;
  localparam int PERIOD_W = 17;
  localparam int FREQ_W   = 24;
  localparam int LOST_W   = 16;
  localparam int NUM_W    = 24;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 2;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 48;

  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CAP_W-1:0] MODULUS_RST = 16'd65535;
  localparam logic [CAP_W-1:0] GLITCH_RST  = 16'd50;
  localparam logic [CAP_W-1:0] WINDOW_RST  = 16'd5;
  localparam logic [NUM_W-1:0] NUMER_RST   = 24'd781250;

  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_MODULUS = 2'd0,
    REG_GLITCH  = 2'd1,
    REG_WINDOW  = 2'd2,
    REG_NUMER   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic              changed;
    logic              ready;
    logic [LOST_W-1:0] lost;
  } meas_status_t;

endpackage

// File: rtl/cpfm_period.sv
// Capture bookkeeping: period, change detection, ready flag and lost counter.
module cpfm_period (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          clear_ready,
  input  logic [cpfm_pkg::CAP_W-1:0]    capture_value,
  input  logic [cpfm_pkg::CAP_W-1:0]    counter_modulus,
  input  logic [cpfm_pkg::CAP_W-1:0]    glitch_minimum,
  input  logic [cpfm_pkg::CAP_W-1:0]    change_window,
  output logic [cpfm_pkg::PERIOD_W-1:0] period,
  output cpfm_pkg::meas_status_t        status,
  output cpfm_pkg::meas_status_t        status_next
);
  import cpfm_pkg::*;

  logic              have_first;
  logic [CAP_W-1:0]  last_capture;
  logic [CAP_W-1:0]  drop;
  logic [CAP_W-1:0]  diff;
  logic [PERIOD_W+0:0] p_ext;
  logic [PERIOD_W+0:0] prev_ext;
  logic [PERIOD_W+0:0] win_ext;
  logic              is_change;
  logic [PERIOD_W-1:0] period_next;

  // The stored period doubles as the previous period for the change test.
  always_comb begin
    drop = last_capture - capture_value;
    if (capture_value >= last_capture) begin
      diff = capture_value - last_capture;
    end else if (counter_modulus >= drop) begin
      diff = counter_modulus - drop;
    end else begin
      diff = '0;
    end
    p_ext    = {2'b00, diff};
    prev_ext = {1'b0, period};
    win_ext  = {2'b00, change_window};
    is_change = (diff > glitch_minimum) &&
                ((p_ext + win_ext < prev_ext) || (p_ext > prev_ext + win_ext));
  end

  always_comb begin
    status_next = status;
    period_next = period;
    if (take && have_first) begin
      period_next = {1'b0, diff};
      status_next.changed = is_change;
      if (status.ready) begin
        if (status.lost != '1) begin
          status_next.lost = status.lost + 1'b1;
        end
      end else begin
        status_next.ready = 1'b1;
        status_next.lost  = '0;
      end
    end else if (clear_ready) begin
      status_next.ready = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_first   <= 1'b0;
      last_capture <= '0;
      period       <= '0;
      status       <= '0;
    end else begin
      period <= period_next;
      status <= status_next;
      if (take) begin
        have_first   <= 1'b1;
        last_capture <= capture_value;
      end
    end
  end

endmodule

// File: rtl/cpfm_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module cpfm_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cpfm_pkg::NUM_W-1:0]    dividend,
  input  logic [cpfm_pkg::PERIOD_W-1:0] divisor,
  output logic                          done,
  output logic [cpfm_pkg::FREQ_W-1:0]   quotient
);
  import cpfm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W-1:0]  dsr;
  logic [NUM_W-1:0]     qreg;
  logic                 zero_div;
  logic [PERIOD_W:0]    trial;
  logic                 ge;

  always_comb begin
    trial = {rem, qreg[NUM_W-1]};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      qreg     <= dividend;
      zero_div <= (divisor == '0);
    end else if (busy) begin
      rem  <= ge ? PERIOD_W'(trial - {1'b0, dsr}) : trial[PERIOD_W-1:0];
      qreg <= {qreg[NUM_W-2:0], ge};
    end
  end

  assign quotient = zero_div ? '0 : qreg;

endmodule

// File: rtl/capture_period_frequency_meter.sv
// Top level of the capture period frequency meter.
//
// Input items arrive on the s_ stream. tuser carries the kind: a capture item
// (tuser 0) carries the timer count in tdata; a read item (tuser 1) asks for
// the frequency and clears the ready flag. Every item gives exactly one
// result on the m_ stream with frequency, change flag, ready flag and the
// lost counter. Registers are to be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// A capture item gives its result in the cycle after it is accepted. A read
// item runs a bit-serial restoring division of the numerator by the period,
// one quotient bit per cycle; when the divider is done, the result is
// loaded into the output register from ST_HOLD. One item is worked on at a
// time; s_tready is high only when no division is running and the output
// register is empty or being emptied. When the receiver stalls, the result
// stays in the output register and no new item is taken. Reset clears all
// flags, the period and the counters, and restores the register defaults.
module capture_period_frequency_meter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cpfm_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] capture_value
  input  logic                           s_tuser,   // [0] kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [23:0] frequency, [24] freq_changed, [25] meas_ready, [41:26] meas_lost, zero fill
  output logic [cpfm_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [cpfm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cpfm_pkg::CFG_W-1:0]     cfg_data
);
  import cpfm_pkg::*;

  logic [CAP_W-1:0]    counter_modulus;
  logic [CAP_W-1:0]    glitch_minimum;
  logic [CAP_W-1:0]    change_window;
  logic [NUM_W-1:0]    freq_numerator;

  state_t              state;
  state_t              state_next;
  logic                slot_free;
  logic                accept;
  logic                take_cap;
  logic                take_read;
  logic                load_div;
  logic [PERIOD_W-1:0] period;
  meas_status_t        status;
  meas_status_t        status_next;
  logic                div_done;
  logic [FREQ_W-1:0]   quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_modulus <= MODULUS_RST;
      glitch_minimum  <= GLITCH_RST;
      change_window   <= WINDOW_RST;
      freq_numerator  <= NUMER_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODULUS: counter_modulus <= cfg_data[CAP_W-1:0];
        REG_GLITCH:  glitch_minimum  <= cfg_data[CAP_W-1:0];
        REG_WINDOW:  change_window   <= cfg_data[CAP_W-1:0];
        REG_NUMER:   freq_numerator  <= cfg_data[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  assign slot_free = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign take_cap  = accept && (s_tuser == KIND_CAPTURE);
  assign take_read = accept && (s_tuser == KIND_READ);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take_read) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_HOLD;
      ST_HOLD: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    load_div = 1'b0;
    case (state)
      ST_IDLE: s_tready = slot_free;
      ST_HOLD: load_div = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  cpfm_period u_period (
    .clk             (clk),
    .rst             (rst),
    .take            (take_cap),
    .clear_ready     (take_read),
    .capture_value   (s_tdata[CAP_W-1:0]),
    .counter_modulus (counter_modulus),
    .glitch_minimum  (glitch_minimum),
    .change_window   (change_window),
    .period          (period),
    .status          (status),
    .status_next     (status_next)
  );

  cpfm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (take_read),
    .dividend (freq_numerator),
    .divisor  (period),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take_cap || load_div) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // A capture result is taken from the updated flags in the accept cycle.
  always_ff @(posedge clk) begin
    if (take_cap) begin
      m_tdata <= {6'd0, status_next.lost, status_next.ready, status_next.changed,
                  FREQ_W'(0)};
    end else if (load_div) begin
      m_tdata <= {6'd0, status.lost, status.ready, status.changed, quotient};
    end
  end

endmodule

// File: rtl/cpfm_checker.sv
// Port-level checks of the capture period frequency meter, bound to the top level.
module cpfm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cpfm_pkg::M_TDATA_W-1:0] m_tdata
);
  import cpfm_pkg::*;

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // A held result keeps its item until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // A capture item gives a zero-frequency result in the next cycle.
  a_capture_result: assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready && s_tuser == KIND_CAPTURE |=>
        m_tvalid && m_tdata[FREQ_W-1:0] == '0)
    else $error("capture item did not give its result");

  // Once a read item is taken, s_tready is checked to go low as its division starts.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready && s_tuser == KIND_READ |=> !s_tready)
    else $error("item taken while a division runs");

endmodule

bind capture_period_frequency_meter cpfm_checker u_cpfm_checker (.*);
